@@ rtl/iidl_pkg.sv @@
// ----------------------------------------------------------------------------
// iidl_pkg - shared definitions for the indexed insert/delete list
// Field widths, operation and status codes, port packing and the command
// struct broadcast to the storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package iidl_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int KIND_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 7;

  // packed port widths; the tdata widths are rounded up to whole bytes
  localparam int IN_TDATA_W  = 40;  // position, value
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 48;  // read_value, status, occupancy

  // operation codes
  localparam logic [KIND_W-1:0] OP_READ   = 3'd0;
  localparam logic [KIND_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] OP_AT     = 3'd3;
  localparam logic [KIND_W-1:0] OP_DELETE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // value returned when nothing is read
  localparam logic [VAL_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

  // command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at the insert position
    logic del;  // close the slot at the delete position
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/indexed_insert_delete_list_core.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core - bounded ordered list of 32-bit words
// Each accepted word passes the states idle (accept), exec (cell update) and
// reduce (read merge, set by the registered group level of the read tree);
// a new word is accepted only once the block is back in idle.
// A stalled result holds the block in the merge cycle until it is taken.
// Reset (rst_n low, synchronous) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_delete_list_core #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  wire  [iidl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  wire  [iidl_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [31:0] read_value, [33:32] status, [40:34] occupancy, [47:41] zero
  output logic [iidl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import iidl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [CMP_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_rd_r;
  logic [ST_W-1:0]  out_st_r;
  logic [OCC_W-1:0] out_occ_r;

  cell_cmd_t        cmd;
  logic [CMP_W-1:0] ins_pos;
  logic [CMP_W-1:0] cell_pos;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             in_acc;
  logic             out_load;
  logic [VAL_W-1:0] tree_rd;
  logic [VAL_W-1:0] cell_q [CAPACITY];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_REDUCE) && (!out_valid_r || out_tready);
  assign cnt_ext   = CMP_W'(cnt_r);
  assign full      = (cnt_r >= CNT_W'(CAPACITY));

  // decode the held operation against the current count
  always_comb begin
    cmd       = '0;
    ins_pos   = pos_r;
    st_nxt    = ST_OK;
    rd_ok_nxt = 1'b0;
    case (kind_r)
      OP_READ: begin
        if (pos_r < cnt_ext) rd_ok_nxt = 1'b1;
        else                 st_nxt    = ST_RANGE;
      end
      OP_HEAD: begin
        ins_pos = '0;
        if (full) st_nxt  = ST_FULL;
        else      cmd.ins = 1'b1;
      end
      OP_TAIL: begin
        ins_pos = cnt_ext;
        if (full) st_nxt  = ST_FULL;
        else      cmd.ins = 1'b1;
      end
      OP_AT: begin
        if (pos_r > cnt_ext) st_nxt  = ST_RANGE;
        else if (full)       st_nxt  = ST_FULL;
        else                 cmd.ins = 1'b1;
      end
      OP_DELETE: begin
        if (pos_r < cnt_ext) cmd.del = 1'b1;
        else                 st_nxt  = ST_RANGE;
      end
      default: begin
        st_nxt = ST_RANGE;
      end
    endcase
    // act on the cells only in the update cycle
    if (state_r != S_EXEC) begin
      cmd = '0;
    end
  end

  assign cell_pos = cmd.ins ? ins_pos : pos_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.del) cnt_nxt = cnt_r - CNT_W'(1);
  end

  // advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_REDUCE;
      S_REDUCE: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load)                    out_valid_r <= 1'b1;
      else if (out_tready)             out_valid_r <= 1'b0;
    end
  end

  // latch the accepted word, the decode results and the result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_tuser[KIND_W-1:0];
      pos_r  <= CMP_W'(in_tdata[POS_W-1:0]);
      val_r  <= in_tdata[POS_W +: VAL_W];
    end
    if (state_r == S_EXEC) begin
      st_r    <= st_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    if (out_load) begin
      out_rd_r  <= rd_ok_r ? tree_rd : NO_VALUE;
      out_st_r  <= st_r;
      out_occ_r <= OCC_W'(cnt_r);
    end
  end

  // row of storage cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lower_w;
    logic [VAL_W-1:0] upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_upper
      assign upper_w = cell_q[i+1];
    end
    iidl_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (cell_pos),
      .cnt     (cnt_ext),
      .value   (val_r),
      .lower_q (lower_w),
      .upper_q (upper_w),
      .data_q  (cell_q[i])
    );
  end

  // read selection, sampled before the cells update
  iidl_rd_tree #(
    .CAPACITY (CAPACITY),
    .CMP_W    (CMP_W)
  ) u_rd_tree (
    .clk     (clk),
    .load    (state_r == S_EXEC),
    .pos     (pos_r),
    .cell_q  (cell_q),
    .rd_data (tree_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - VAL_W - ST_W - OCC_W)'(0), out_occ_r, out_st_r, out_rd_r};

endmodule

`default_nettype wire

@@ rtl/iidl_cell.sv @@
// ----------------------------------------------------------------------------
// iidl_cell - one storage cell of the list
// Holds one entry; on command it loads a new value, takes the word of its
// lower neighbor (insert shift) or of its upper neighbor (delete shift).
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  wire                          clk,
  input  iidl_pkg::cell_cmd_t          cmd,
  input  wire  [CMP_W-1:0]             pos,
  input  wire  [CMP_W-1:0]             cnt,
  input  wire  [iidl_pkg::VAL_W-1:0]   value,
  input  wire  [iidl_pkg::VAL_W-1:0]   lower_q,
  input  wire  [iidl_pkg::VAL_W-1:0]   upper_q,
  output logic [iidl_pkg::VAL_W-1:0]   data_q
);
  import iidl_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // pick load, shift up, shift down or hold
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && (MY_IDX > pos) && (MY_IDX <= cnt)) begin
      data_nxt = lower_q;
    end else if (cmd.ins && (MY_IDX == pos)) begin
      data_nxt = value;
    end else if (cmd.del && (MY_IDX >= pos) && ((MY_IDX + CMP_W'(1)) < cnt)) begin
      data_nxt = upper_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

@@ rtl/iidl_rd_tree.sv @@
// ----------------------------------------------------------------------------
// iidl_rd_tree - registered read selection over the cell row
// First level selects the addressed word within groups of eight cells and
// registers it; second level ORs the group words together.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_rd_tree #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF,
  parameter int CMP_W    = 7
) (
  input  wire                          clk,
  input  wire                          load,
  input  wire  [CMP_W-1:0]             pos,
  input  wire  [iidl_pkg::VAL_W-1:0]   cell_q [CAPACITY],
  output logic [iidl_pkg::VAL_W-1:0]   rd_data
);
  import iidl_pkg::*;

  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  logic [VAL_W-1:0] term   [NGRP][GRP];
  logic [VAL_W-1:0] grp_nxt[NGRP];
  logic [VAL_W-1:0] grp_r  [NGRP];

  // mask every cell except the addressed one
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar j = 0; j < GRP; j++) begin : g_term
      localparam int CI = g * GRP + j;
      if (CI < CAPACITY) begin : g_live
        assign term[g][j] = (CMP_W'(CI) == pos) ? cell_q[CI] : '0;
      end else begin : g_pad
        assign term[g][j] = '0;
      end
    end

    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_nxt[g] = grp_nxt[g] | term[g][k];
      end
    end

    // capture group word on load, hold otherwise
    always_ff @(posedge clk) begin
      if (load) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // merge the group words
  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

`default_nettype wire

@@ rtl/iidl_checker.sv @@
// ----------------------------------------------------------------------------
// iidl_checker - port level checks for the indexed insert/delete list
// Watches the stream ports of the core and flags inconsistent result words.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_checker #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [iidl_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import iidl_pkg::*;

  logic [VAL_W-1:0] rd_f;
  logic [ST_W-1:0]  st_f;
  logic [OCC_W-1:0] occ_f;

  assign rd_f  = out_tdata[VAL_W-1:0];
  assign st_f  = out_tdata[VAL_W +: ST_W];
  assign occ_f = out_tdata[VAL_W+ST_W +: OCC_W];

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // only defined status codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_f == ST_OK) || (st_f == ST_RANGE) || (st_f == ST_FULL))
    else $error("undefined status code");

  // a refused operation reads nothing
  a_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st_f != ST_OK) |-> rd_f == NO_VALUE)
    else $error("refused operation returned a value");

  // full status only at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st_f == ST_FULL) |-> occ_f == OCC_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind indexed_insert_delete_list_core iidl_checker #(
  .CAPACITY (CAPACITY)
) u_iidl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
